FILE: rtl/ppm_frame_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// PPM frame decoder assertion macros
// Concurrent assertion shorthands clocked by clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PPM_FRAME_DECODER_TOP_ASSERT_SVH
`define PPM_FRAME_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define PPMD_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PPMD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ppmd_pkg.sv
// ----------------------------------------------------------------------------
// PPM frame decoder package
// Shared widths, register indexes, word types and control structs.
// ----------------------------------------------------------------------------
package ppmd_pkg;

   // Channel capacity of one frame.
   localparam int MAX_CHANNELS = 8;

   // Counter holding 0..MAX_CHANNELS and index into the pulse store.
   localparam int POS_W = $clog2(MAX_CHANNELS + 1);
   localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   localparam int TICK_W  = 16;
   localparam int SCALE_W = 8;
   localparam int US_W    = 16;
   localparam int PROD_W  = TICK_W + SCALE_W;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PULSE_TICKS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PULSE_TICKS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_TO_US     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_MIN_US      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_MAX_US      = 3'd4;

   // Register reset values.
   localparam logic [TICK_W-1:0]  MIN_PULSE_RESET = 16'd90;
   localparam logic [TICK_W-1:0]  MAX_PULSE_RESET = 16'd210;
   localparam logic [SCALE_W-1:0] TICKS_TO_US_RESET = 8'd10;
   localparam logic [US_W-1:0]    OUT_MIN_RESET = 16'd1000;
   localparam logic [US_W-1:0]    OUT_MAX_RESET = 16'd2000;

   typedef struct packed {
      logic [TICK_W-1:0] capture_value;
      logic              publish_blocked;
   } req_type;

   typedef struct packed {
      logic [2:0]      channel_index;
      logic [US_W-1:0] pulse_width_us;
      logic [3:0]      frame_channels;
      logic            last;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0]  min_pulse_ticks;
      logic [TICK_W-1:0]  max_pulse_ticks;
      logic [SCALE_W-1:0] ticks_to_us;
      logic [US_W-1:0]    out_min_us;
      logic [US_W-1:0]    out_max_us;
   } cfg_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;
      logic mul;
      logic load;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic frame_start;
      logic last_word;
      logic out_free;
   } sts_type;

endpackage

FILE: rtl/ppmd_csr.sv
// ----------------------------------------------------------------------------
// PPM frame decoder configuration registers
// Holds the five configuration registers written through the csr channel.
// ----------------------------------------------------------------------------
module ppmd_csr
   import ppmd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_PULSE_TICKS: cfg_in.min_pulse_ticks = csr_wdata;
            CSR_MAX_PULSE_TICKS: cfg_in.max_pulse_ticks = csr_wdata;
            CSR_TICKS_TO_US:     cfg_in.ticks_to_us     = csr_wdata[SCALE_W-1:0];
            CSR_OUT_MIN_US:      cfg_in.out_min_us      = csr_wdata;
            CSR_OUT_MAX_US:      cfg_in.out_max_us      = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_pulse_ticks <= MIN_PULSE_RESET;
         cfg_ff.max_pulse_ticks <= MAX_PULSE_RESET;
         cfg_ff.ticks_to_us     <= TICKS_TO_US_RESET;
         cfg_ff.out_min_us      <= OUT_MIN_RESET;
         cfg_ff.out_max_us      <= OUT_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/ppmd_ctrl.sv
// ----------------------------------------------------------------------------
// PPM frame decoder controller
// Sequences capture, then multiply and load for each published channel.
// ----------------------------------------------------------------------------
module ppmd_ctrl
   import ppmd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.mul     = 1'b0;
      cmd.load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid && sts.frame_start) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = sts.out_free;
            if (sts.out_free) begin
               state_in = sts.last_word ? ST_IDLE : ST_MUL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/ppmd_dp.sv
// ----------------------------------------------------------------------------
// PPM frame decoder datapath
// Gap measurement, pulse store, scaling multiplier, clamp and output register.
// ----------------------------------------------------------------------------
module ppmd_dp
   import ppmd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cfg_type cfg,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [TICK_W-1:0] prev_ff;
   logic [TICK_W-1:0] prev_in;
   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  pos_in;
   logic [POS_W-1:0]  frame_ff;
   logic [POS_W-1:0]  frame_in;
   logic [POS_W-1:0]  k_ff;
   logic [POS_W-1:0]  k_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_data_ff;
   rsp_type           rsp_data_in;
   logic [PROD_W-1:0] product_ff;

   logic [TICK_W-1:0] pulse_store [MAX_CHANNELS];

   logic [TICK_W-1:0] gap;
   logic              is_pulse;
   logic              has_room;
   logic              last_word;
   logic [US_W-1:0]   clamped;

   assign gap       = req_data.capture_value - prev_ff;
   assign is_pulse  = (gap > cfg.min_pulse_ticks) && (gap < cfg.max_pulse_ticks);
   assign has_room  = (pos_ff < POS_W'(MAX_CHANNELS));
   assign last_word = (k_ff == frame_ff - POS_W'(1));

   assign sts.frame_start = !is_pulse && (pos_ff != '0) && !req_data.publish_blocked;
   assign sts.last_word   = last_word;
   assign sts.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // When the limits cross, products below out_min give out_min and all others give out_max.
   always_comb begin
      if (product_ff < PROD_W'(cfg.out_min_us)) begin
         clamped = cfg.out_min_us;
      end else if (product_ff > PROD_W'(cfg.out_max_us)) begin
         clamped = cfg.out_max_us;
      end else begin
         clamped = product_ff[US_W-1:0];
      end
   end

   always_comb begin
      prev_in  = prev_ff;
      pos_in   = pos_ff;
      frame_in = frame_ff;
      k_in     = k_ff;
      if (cmd.capture) begin
         prev_in = req_data.capture_value;
         if (is_pulse) begin
            if (has_room) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end else begin
            pos_in = '0;
            k_in   = '0;
            if (pos_ff != '0) begin
               frame_in = pos_ff;
            end
         end
      end
      if (cmd.load) begin
         k_in = k_ff + POS_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = cmd.load || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = rsp_data_ff;
      if (cmd.load) begin
         rsp_data_in.channel_index  = 3'(k_ff);
         rsp_data_in.pulse_width_us = clamped;
         rsp_data_in.frame_channels = 4'(frame_ff);
         rsp_data_in.last           = last_word;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture && is_pulse && has_room) begin
         pulse_store[pos_ff[IDX_W-1:0]] <= gap;
      end
      if (cmd.mul) begin
         product_ff <= PROD_W'(cfg.ticks_to_us) * PROD_W'(pulse_store[k_ff[IDX_W-1:0]]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         pos_ff       <= '0;
         frame_ff     <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         pos_ff       <= pos_in;
         frame_ff     <= frame_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: rtl/ppm_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// PPM frame decoder top level
// Decodes pulse-position frames from timer captures into channel widths.
// ----------------------------------------------------------------------------
//
//   Channel | Ports         | Word
//   --------+---------------+-------------------------------------------------
//   request | req_*         | one timer capture taken at a rising edge
//   result  | rsp_*         | one published channel width of a frame
//   config  | csr_*         | register index and write data, never stalls
//
// A sync that publishes a frame of N channels keeps req_ready low while
// each channel passes once through the shared scaling multiplier and
// once into the output register, and while the result side stalls.
// Reset is synchronous and restores the registers to their defaults.
// The output register lets the next capture in while the last word of
// a frame still waits.
//
module ppm_frame_decoder_top
   import ppmd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   // Configuration registers; the user must write them only while the block is idle (not enforced here).
   ppmd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The controller accepts captures only when idle and then steps through
   // the stored channels of a completed frame.
   ppmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath measures gaps, stores channel pulses and forms each word.
   ppmd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/ppmd_checker.sv
// ----------------------------------------------------------------------------
// PPM frame decoder port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "ppm_frame_decoder_top_assert.svh"

module ppmd_checker
   import ppmd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input req_type                req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rsp_type                rsp_data,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic unused_ok;
   assign unused_ok = ^{req_valid, req_data, csr_index, csr_wdata};

   // A stalled result word holds.
   `PPMD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp word changed while stalled")

   // While a frame is still being published no capture is taken.
   `PPMD_ASSERT(a_busy_in_frame, rsp_valid && !rsp_data.last, !req_ready, "capture taken mid frame")

   // The last mark falls on the final channel of the frame.
   `PPMD_ASSERT(a_last_index, rsp_valid, rsp_data.last == ({1'b0, rsp_data.channel_index} == rsp_data.frame_channels - 4'd1), "last mark misplaced")

   // Configuration writes are never stalled.
   `PPMD_ASSERT(a_csr_ready, csr_valid, csr_ready, "csr write stalled")

endmodule

bind ppm_frame_decoder_top ppmd_checker u_checker (.*);
